// File: src/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types and constants for the cubic Bezier split pipeline.
// ----------------------------------------------------------------------------
package cbs_pkg;

    // Fraction bits of the split parameter t
    localparam int T_FRAC_BITS = 16;

    // Coordinate width (signed Q16.16)
    localparam int COORD_W = 32;

    // t after saturation to 1.0 needs one integer bit
    localparam int T_W = T_FRAC_BITS + 1;

    // Difference of two coordinates, and its product with t
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = DIFF_W + T_W;

    // Exactly 1.0 in t format
    localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC_BITS;
    localparam logic [31:0] T_ONE_32 = 32'(1) << T_FRAC_BITS;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [T_W-1:0] tfrac_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    // Register enables of one two-stage interpolator
    typedef struct packed {
        logic mul;
        logic add;
    } lerp_en_t;

endpackage

// File: src/cbs_lerp.sv
// ----------------------------------------------------------------------------
// cbs_lerp
// Two-stage point interpolator: a + floor((b - a) * t / 2^T_FRAC_BITS).
// ----------------------------------------------------------------------------
module cbs_lerp
(
    input  logic              clk,
    input  cbs_pkg::lerp_en_t en,
    input  cbs_pkg::point_t   a,
    input  cbs_pkg::point_t   b,
    input  cbs_pkg::tfrac_t   t,
    output cbs_pkg::point_t   res
);

    logic signed [cbs_pkg::DIFF_W-1:0] diff_x;
    logic signed [cbs_pkg::DIFF_W-1:0] diff_y;
    logic signed [cbs_pkg::T_W:0]      t_s;
    logic signed [cbs_pkg::PROD_W-1:0] prod_x_next;
    logic signed [cbs_pkg::PROD_W-1:0] prod_y_next;
    logic signed [cbs_pkg::PROD_W-1:0] prod_x_reg;
    logic signed [cbs_pkg::PROD_W-1:0] prod_y_reg;
    cbs_pkg::point_t                   a_reg;
    logic signed [cbs_pkg::PROD_W-1:0] sum_x;
    logic signed [cbs_pkg::PROD_W-1:0] sum_y;
    cbs_pkg::point_t                   res_next;
    cbs_pkg::point_t                   res_reg;

    // Widen the difference so it never overflows
    assign diff_x = cbs_pkg::DIFF_W'(b.x) - cbs_pkg::DIFF_W'(a.x);
    assign diff_y = cbs_pkg::DIFF_W'(b.y) - cbs_pkg::DIFF_W'(a.y);
    assign t_s    = $signed({1'b0, t});

    // Scale the difference by t
    assign prod_x_next = cbs_pkg::PROD_W'(diff_x * t_s);
    assign prod_y_next = cbs_pkg::PROD_W'(diff_y * t_s);

    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            a_reg      <= a;
        end
    end

    // Floor the product and add back the start point
    assign sum_x = cbs_pkg::PROD_W'(a_reg.x) + (prod_x_reg >>> cbs_pkg::T_FRAC_BITS);
    assign sum_y = cbs_pkg::PROD_W'(a_reg.y) + (prod_y_reg >>> cbs_pkg::T_FRAC_BITS);

    always_comb
    begin
        res_next.x = sum_x[cbs_pkg::COORD_W-1:0];
        res_next.y = sum_y[cbs_pkg::COORD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.add)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// File: src/cubic_bezier_split.sv
// ----------------------------------------------------------------------------
// cubic_bezier_split
// De Casteljau subdivision of a cubic Bezier curve at a parameter t.
// ----------------------------------------------------------------------------
// The item channel (item_valid / item_stall) carries four control points in
// signed Q16.16 and the split parameter split_at (unsigned, T_FRAC_BITS
// fraction bits, saturated at 1.0). The result channel (result_valid /
// result_stall) returns two items for each input: the left half's four
// control points with is_right_half low, then the right half's with
// is_right_half high.
// The left half is presented after the six register stages and the output
// register, the right half once the left half is taken. The stages, a
// multiply stage and an add stage for each of the three interpolation
// levels, accept an item every cycle while nothing stalls; the single result
// port, busy with both halves of each item, keeps the sustained rate lower.
// When the receiver stalls, the output register holds its item and the stages
// behind it fill up; once all are full, item_stall rises. Nothing is dropped
// or repeated.
// Reset clears every valid bit and the half select; no result is presented
// until an item has passed through.
// ----------------------------------------------------------------------------
module cubic_bezier_split
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                item_valid,
    output logic                item_stall,
    input  logic signed [31:0]  start_x,
    input  logic signed [31:0]  start_y,
    input  logic signed [31:0]  ctrl_a_x,
    input  logic signed [31:0]  ctrl_a_y,
    input  logic signed [31:0]  ctrl_b_x,
    input  logic signed [31:0]  ctrl_b_y,
    input  logic signed [31:0]  end_x,
    input  logic signed [31:0]  end_y,
    input  logic        [15:0]  split_at,

    output logic                result_valid,
    input  logic                result_stall,
    output logic signed [31:0]  out_p0_x,
    output logic signed [31:0]  out_p0_y,
    output logic signed [31:0]  out_p1_x,
    output logic signed [31:0]  out_p1_y,
    output logic signed [31:0]  out_p2_x,
    output logic signed [31:0]  out_p2_y,
    output logic signed [31:0]  out_p3_x,
    output logic signed [31:0]  out_p3_y,
    output logic                is_right_half
);

    localparam int NUM_STAGES = 6;

    // Values that travel alongside the interpolators
    typedef struct packed {
        cbs_pkg::tfrac_t t;
        cbs_pkg::point_t p0;
        cbs_pkg::point_t p3;
        cbs_pkg::point_t ab;
        cbs_pkg::point_t cd;
        cbs_pkg::point_t abc;
        cbs_pkg::point_t bcd;
    } carry_t;

    logic [31:0]          split_ext;
    cbs_pkg::tfrac_t      t_sat;
    cbs_pkg::point_t      pt0;
    cbs_pkg::point_t      pt1;
    cbs_pkg::point_t      pt2;
    cbs_pkg::point_t      pt3;
    carry_t               carry_in;

    logic [NUM_STAGES:1]  valid_reg;
    logic [NUM_STAGES+1:1] stage_en;
    carry_t               carry_reg [NUM_STAGES:1];

    cbs_pkg::lerp_en_t    lvl1_en;
    cbs_pkg::lerp_en_t    lvl2_en;
    cbs_pkg::lerp_en_t    lvl3_en;
    cbs_pkg::point_t      ab;
    cbs_pkg::point_t      bc;
    cbs_pkg::point_t      cd;
    cbs_pkg::point_t      abc;
    cbs_pkg::point_t      bcd;
    cbs_pkg::point_t      mid;

    logic                 out_valid_reg;
    logic                 half_reg;
    logic                 out_take;
    logic                 out_load;
    cbs_pkg::point_t      left_reg [4];
    cbs_pkg::point_t      right_reg [4];
    cbs_pkg::point_t      sel [4];

    // Saturate t at exactly 1.0
    assign split_ext = {16'b0, split_at};
    assign t_sat = (split_ext > cbs_pkg::T_ONE_32) ? cbs_pkg::T_ONE
                                                   : split_ext[cbs_pkg::T_W-1:0];

    assign pt0 = '{x: start_x,  y: start_y};
    assign pt1 = '{x: ctrl_a_x, y: ctrl_a_y};
    assign pt2 = '{x: ctrl_b_x, y: ctrl_b_y};
    assign pt3 = '{x: end_x,    y: end_y};

    always_comb
    begin
        carry_in    = '0;
        carry_in.t  = t_sat;
        carry_in.p0 = pt0;
        carry_in.p3 = pt3;
    end

    // Advance a stage when it is empty or the next one advances
    assign out_take = out_valid_reg && !result_stall;
    assign out_load = !out_valid_reg || (out_take && half_reg);

    always_comb
    begin
        stage_en[NUM_STAGES+1] = out_load;
        for (int k = NUM_STAGES; k >= 1; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign item_stall = !stage_en[1];

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[1])
            begin
                valid_reg[1] <= item_valid;
            end
            for (int k = 2; k <= NUM_STAGES; k++)
            begin
                if (stage_en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Carry the end points and finished intermediate points
    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            carry_reg[1] <= carry_in;
        end
        if (stage_en[2])
        begin
            carry_reg[2] <= carry_reg[1];
        end
        if (stage_en[3])
        begin
            carry_reg[3].t   <= carry_reg[2].t;
            carry_reg[3].p0  <= carry_reg[2].p0;
            carry_reg[3].p3  <= carry_reg[2].p3;
            carry_reg[3].ab  <= ab;
            carry_reg[3].cd  <= cd;
            carry_reg[3].abc <= carry_reg[2].abc;
            carry_reg[3].bcd <= carry_reg[2].bcd;
        end
        if (stage_en[4])
        begin
            carry_reg[4] <= carry_reg[3];
        end
        if (stage_en[5])
        begin
            carry_reg[5].t   <= carry_reg[4].t;
            carry_reg[5].p0  <= carry_reg[4].p0;
            carry_reg[5].p3  <= carry_reg[4].p3;
            carry_reg[5].ab  <= carry_reg[4].ab;
            carry_reg[5].cd  <= carry_reg[4].cd;
            carry_reg[5].abc <= abc;
            carry_reg[5].bcd <= bcd;
        end
        if (stage_en[6])
        begin
            carry_reg[6] <= carry_reg[5];
        end
    end

    assign lvl1_en = '{mul: stage_en[1], add: stage_en[2]};
    assign lvl2_en = '{mul: stage_en[3], add: stage_en[4]};
    assign lvl3_en = '{mul: stage_en[5], add: stage_en[6]};

    // First level: three interpolations between the control points
    cbs_lerp u_lerp_ab
    (
        .clk (clk),
        .en  (lvl1_en),
        .a   (pt0),
        .b   (pt1),
        .t   (t_sat),
        .res (ab)
    );

    cbs_lerp u_lerp_bc
    (
        .clk (clk),
        .en  (lvl1_en),
        .a   (pt1),
        .b   (pt2),
        .t   (t_sat),
        .res (bc)
    );

    cbs_lerp u_lerp_cd
    (
        .clk (clk),
        .en  (lvl1_en),
        .a   (pt2),
        .b   (pt3),
        .t   (t_sat),
        .res (cd)
    );

    // Second level
    cbs_lerp u_lerp_abc
    (
        .clk (clk),
        .en  (lvl2_en),
        .a   (ab),
        .b   (bc),
        .t   (carry_reg[2].t),
        .res (abc)
    );

    cbs_lerp u_lerp_bcd
    (
        .clk (clk),
        .en  (lvl2_en),
        .a   (bc),
        .b   (cd),
        .t   (carry_reg[2].t),
        .res (bcd)
    );

    // Third level: the split point on the curve
    cbs_lerp u_lerp_mid
    (
        .clk (clk),
        .en  (lvl3_en),
        .a   (abc),
        .b   (bcd),
        .t   (carry_reg[4].t),
        .res (mid)
    );

    // Output register: hold both halves, present left then right
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= valid_reg[NUM_STAGES];
            half_reg      <= 1'b0;
        end
        else if (out_take)
        begin
            half_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            left_reg[0]  <= carry_reg[6].p0;
            left_reg[1]  <= carry_reg[6].ab;
            left_reg[2]  <= carry_reg[6].abc;
            left_reg[3]  <= mid;
            right_reg[0] <= mid;
            right_reg[1] <= carry_reg[6].bcd;
            right_reg[2] <= carry_reg[6].cd;
            right_reg[3] <= carry_reg[6].p3;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sel[i] = half_reg ? right_reg[i] : left_reg[i];
        end
    end

    assign result_valid  = out_valid_reg;
    assign is_right_half = half_reg;
    assign out_p0_x      = sel[0].x;
    assign out_p0_y      = sel[0].y;
    assign out_p1_x      = sel[1].x;
    assign out_p1_y      = sel[1].y;
    assign out_p2_x      = sel[2].x;
    assign out_p2_y      = sel[2].y;
    assign out_p3_x      = sel[3].x;
    assign out_p3_y      = sel[3].y;

endmodule

// File: src/cbs_check.sv
// ----------------------------------------------------------------------------
// cbs_check
// Port-level checks on the result channel of the Bezier split block.
// ----------------------------------------------------------------------------
module cbs_check
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                result_valid,
    input  logic                result_stall,
    input  logic signed [31:0]  out_p0_x,
    input  logic signed [31:0]  out_p0_y,
    input  logic signed [31:0]  out_p3_x,
    input  logic signed [31:0]  out_p3_y,
    input  logic                is_right_half
);

    // Hold a stalled item
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(out_p0_x)
            && $stable(out_p3_y) && $stable(is_right_half))
        else $error("stalled result item changed");

    // A taken left half is followed at once by its right half
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !is_right_half
            |=> result_valid && is_right_half)
        else $error("right half did not follow left half");

    // The halves meet at the split point
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !is_right_half
            |=> out_p0_x == $past(out_p3_x) && out_p0_y == $past(out_p3_y))
        else $error("right half does not start at split point");

    // A right half is only ever shown after its left half was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && is_right_half && !$past(is_right_half)
            |-> $past(result_valid) && !$past(result_stall))
        else $error("right half shown without left half");

endmodule

bind cubic_bezier_split cbs_check u_cbs_check
(
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .out_p0_x      (out_p0_x),
    .out_p0_y      (out_p0_y),
    .out_p3_x      (out_p3_x),
    .out_p3_y      (out_p3_y),
    .is_right_half (is_right_half)
);
